FILE: hw/rtl/hse_pkg.sv
`timescale 1ns / 1ps

package hse_pkg;

    // Field widths of the input and output words
    localparam int KIND_W      = 2;
    localparam int SYM_W       = 8;
    localparam int CODE_W      = 32;
    localparam int LEN_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int PEND_W      = 7;
    localparam int PCNT_W      = 3;

    // Longest codeword the table keeps; longer lengths saturate
    localparam int MAX_CODE_LEN = 32;

    // Code table geometry: one entry per symbol, {length, codeword}
    localparam int TAB_DEPTH   = 1 << SYM_W;
    localparam int ENT_W       = LEN_W + CODE_W;

    // Bit accumulator: leftover bits plus one full codeword
    localparam int ACC_W       = PEND_W + MAX_CODE_LEN;
    localparam int TOT_W       = $clog2(ACC_W + 1);
    localparam int MAX_BYTES   = ACC_W / BYTE_W;
    localparam int CNT_W       = $clog2(MAX_BYTES + 2);

    // Port packing
    localparam int S_TDATA_W   = 48;
    localparam int S_TUSER_W   = KIND_W;
    localparam int M_TDATA_W   = BYTE_W;
    localparam int M_TUSER_W   = 2;

    // Input word kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_FINISH = 2'd2
    } t_kind;

endpackage

FILE: hw/rtl/huffman_stream_encoder.sv
`timescale 1ns / 1ps

// Huffman encoder and bit packer. The 256-entry code table sits in a
// synchronous RAM that is read as a word is accepted; a valid bit per
// entry makes every entry read as "absent" after reset, so no clearing pass
// is needed and the block takes words right out of reset. Table loads,
// absent symbols, kind 3 and data words that complete no byte never wait on
// the output register. A data word that completes n bytes (up to 4 with 32-bit
// codes) or a finish word (one byte) hands its bytes to an output register that
// drives one byte per cycle while m_axis_tready is high; the next word can
// enter that register as the last byte of the previous one is taken. An accepted
// word passes through the stage 1 registers and then the output register.
module huffman_stream_encoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave side
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] symbol, [39:8] code_bits, [45:40] code_length, [47:46] zero
    input  logic [hse_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] kind
    input  logic [hse_pkg::S_TUSER_W-1:0]   s_axis_tuser,
    // master side
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] out_byte
    output logic [hse_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [0] byte_valid, [1] end_of_stream
    output logic [hse_pkg::M_TUSER_W-1:0]   m_axis_tuser,
    output logic                            m_axis_tlast
);

    // Input word unpack
    hse_pkg::t_kind                 in_kind;
    logic [hse_pkg::SYM_W-1:0]      in_sym;
    logic [hse_pkg::CODE_W-1:0]     in_code;
    logic [hse_pkg::LEN_W-1:0]      in_len;
    logic [hse_pkg::LEN_W-1:0]      in_len_sat;
    logic [hse_pkg::CODE_W-1:0]     in_code_msk;
    logic                           in_acc;

    assign in_kind = hse_pkg::t_kind'(s_axis_tuser);
    assign in_sym  = s_axis_tdata[hse_pkg::SYM_W-1:0];
    assign in_code = s_axis_tdata[hse_pkg::SYM_W +: hse_pkg::CODE_W];
    assign in_len  = s_axis_tdata[hse_pkg::SYM_W + hse_pkg::CODE_W +: hse_pkg::LEN_W];
    assign in_acc  = s_axis_tvalid && s_axis_tready;

    // Saturate the length and drop codeword bits above it
    always_comb begin
        in_len_sat = (in_len > hse_pkg::LEN_W'(hse_pkg::MAX_CODE_LEN))
                   ? hse_pkg::LEN_W'(hse_pkg::MAX_CODE_LEN) : in_len;
        in_code_msk = in_code & ~({hse_pkg::CODE_W{1'b1}} << in_len_sat);
    end

    // Code table RAM: written on a load, read for every accepted word
    logic [hse_pkg::ENT_W-1:0]      r_mem [hse_pkg::TAB_DEPTH];
    logic [hse_pkg::ENT_W-1:0]      r_rd;

    always_ff @(posedge i_clk) begin
        if (in_acc && in_kind == hse_pkg::KIND_LOAD) begin
            r_mem[in_sym] <= {in_len_sat, in_code_msk};
        end
        if (in_acc) begin
            r_rd <= r_mem[in_sym];
        end
    end

    // Per-entry valid bits; unwritten entries read as length zero
    logic [hse_pkg::TAB_DEPTH-1:0]  r_tab_vld;
    logic                           r_ent_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_vld <= '0;
        end else if (in_acc && in_kind == hse_pkg::KIND_LOAD) begin
            r_tab_vld[in_sym] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ent_vld <= r_tab_vld[in_sym];
        end
    end

    // Stage 1: word waiting for its table entry to be packed
    logic                           r_s1_vld;
    hse_pkg::t_kind                 r_s1_kind;
    logic                           s1_adv;
    logic                           s1_emits;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s1_kind <= hse_pkg::KIND_LOAD;
        end else if (s_axis_tready) begin
            r_s1_vld  <= s_axis_tvalid;
            r_s1_kind <= in_kind;
        end
    end

    assign s_axis_tready = !r_s1_vld || s1_adv;

    // Bit packing: merge pending bits with the codeword
    logic [hse_pkg::PEND_W-1:0]     r_pbits;
    logic [hse_pkg::PCNT_W-1:0]     r_pcnt;
    logic [hse_pkg::LEN_W-1:0]      ent_len;
    logic [hse_pkg::CODE_W-1:0]     ent_code;
    logic [hse_pkg::ACC_W-1:0]      acc;
    logic [hse_pkg::ACC_W-1:0]      acc_aligned;
    logic [hse_pkg::TOT_W-1:0]      total;
    logic [hse_pkg::CNT_W-1:0]      nbytes;
    logic [hse_pkg::PEND_W-1:0]     new_pbits;
    logic [hse_pkg::BYTE_W-1:0]     fin_byte;
    logic                           is_data;
    logic                           is_fin;

    always_comb begin
        ent_len  = r_ent_vld ? r_rd[hse_pkg::CODE_W +: hse_pkg::LEN_W] : '0;
        ent_code = r_rd[hse_pkg::CODE_W-1:0];
        acc = (hse_pkg::ACC_W'(r_pbits) << ent_len) | hse_pkg::ACC_W'(ent_code);
        total = hse_pkg::TOT_W'(r_pcnt) + hse_pkg::TOT_W'(ent_len);
        nbytes = hse_pkg::CNT_W'(total >> 3);
        // first emitted bit moves to the top of the accumulator
        acc_aligned = acc << (hse_pkg::TOT_W'(hse_pkg::ACC_W) - total);
        new_pbits = acc[hse_pkg::PEND_W-1:0]
                  & ~({hse_pkg::PEND_W{1'b1}} << total[hse_pkg::PCNT_W-1:0]);
        // finish: leftover bits padded with zeros on the right
        fin_byte = hse_pkg::BYTE_W'({1'b0, r_pbits} << (4'd8 - {1'b0, r_pcnt}));
        is_data  = (r_s1_kind == hse_pkg::KIND_DATA) && (ent_len != '0);
        is_fin   = (r_s1_kind == hse_pkg::KIND_FINISH);
        s1_emits = (is_data && nbytes != '0) || is_fin;
    end

    // Pending bits advance with stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pbits <= '0;
            r_pcnt  <= '0;
        end else if (s1_adv) begin
            if (is_data) begin
                r_pbits <= new_pbits;
                r_pcnt  <= total[hse_pkg::PCNT_W-1:0];
            end else if (is_fin) begin
                r_pbits <= '0;
                r_pcnt  <= '0;
            end
        end
    end

    // Output register: a run of bytes, first byte in the top bits
    logic [hse_pkg::ACC_W-1:0]      r_chunk;
    logic [hse_pkg::CNT_W-1:0]      r_cnt;
    logic                           r_bval;
    logic                           r_eos;
    logic                           out_take;
    logic                           chunk_free;

    assign out_take   = m_axis_tvalid && m_axis_tready;
    assign chunk_free = (r_cnt == '0) || (r_cnt == hse_pkg::CNT_W'(1) && m_axis_tready);
    assign s1_adv     = r_s1_vld && (!s1_emits || chunk_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (s1_adv && s1_emits) begin
            r_cnt <= is_fin ? hse_pkg::CNT_W'(1) : nbytes;
        end else if (out_take) begin
            r_cnt <= r_cnt - hse_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && s1_emits) begin
            if (is_fin) begin
                r_chunk <= {fin_byte, {(hse_pkg::ACC_W - hse_pkg::BYTE_W){1'b0}}};
                r_bval  <= (r_pcnt != '0);
                r_eos   <= 1'b1;
            end else begin
                r_chunk <= acc_aligned;
                r_bval  <= 1'b1;
                r_eos   <= 1'b0;
            end
        end else if (out_take) begin
            r_chunk <= r_chunk << hse_pkg::BYTE_W;
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tlast  = (r_cnt == hse_pkg::CNT_W'(1));
    assign m_axis_tdata  = r_chunk[hse_pkg::ACC_W-1 -: hse_pkg::BYTE_W];
    assign m_axis_tuser  = {r_eos, r_bval};

`ifndef ASSERT_OFF
    // Byte run never exceeds what one codeword can complete
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= hse_pkg::CNT_W'(hse_pkg::MAX_BYTES))
        else $error("output byte count out of range");

    // Input stalls only behind a word held in stage 1
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_vld)
        else $error("input stalled with stage 1 empty");

    // End of stream is always a single-byte run
    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[1]) |-> m_axis_tlast)
        else $error("end of stream without last");

    // Empty finish carries a zero byte
    a_eos_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tuser[1] && m_axis_tdata == '0))
        else $error("invalid byte outside an empty finish");

    // Pending bits change only as stage 1 retires a word
    a_pend_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s1_adv |=> $stable(r_pcnt))
        else $error("pending count changed without stage 1 advancing");
`endif

endmodule
